/* design/i8080_instruction_decoder_assert.svh */
// assertion macros for the 8080 instruction decoder checks
`ifndef I8080_INSTRUCTION_DECODER_ASSERT_SVH
`define I8080_INSTRUCTION_DECODER_ASSERT_SVH

// same-cycle implication
`define I8080_DEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i8080 decoder check failed");

// next-cycle implication
`define I8080_DEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i8080 decoder check failed");

`endif

/* design/i8080_dec_pkg.sv */
// package: types and mnemonic codes of the 8080 instruction decoder
package i8080_dec_pkg;

  localparam logic [6:0] MN_MOV   = 7'd0;
  localparam logic [6:0] MN_MVI   = 7'd1;
  localparam logic [6:0] MN_LXI   = 7'd2;
  localparam logic [6:0] MN_LDA   = 7'd3;
  localparam logic [6:0] MN_STA   = 7'd4;
  localparam logic [6:0] MN_LHLD  = 7'd5;
  localparam logic [6:0] MN_SHLD  = 7'd6;
  localparam logic [6:0] MN_LDAX  = 7'd7;
  localparam logic [6:0] MN_STAX  = 7'd8;
  localparam logic [6:0] MN_XCHG  = 7'd9;
  localparam logic [6:0] MN_ADD   = 7'd10;
  localparam logic [6:0] MN_ADI   = 7'd18;
  localparam logic [6:0] MN_INR   = 7'd26;
  localparam logic [6:0] MN_DCR   = 7'd27;
  localparam logic [6:0] MN_INX   = 7'd28;
  localparam logic [6:0] MN_DCX   = 7'd29;
  localparam logic [6:0] MN_DAD   = 7'd30;
  localparam logic [6:0] MN_RLC   = 7'd31;
  localparam logic [6:0] MN_JMP   = 7'd39;
  localparam logic [6:0] MN_JNZ   = 7'd40;
  localparam logic [6:0] MN_CALL  = 7'd48;
  localparam logic [6:0] MN_CNZ   = 7'd49;
  localparam logic [6:0] MN_RET   = 7'd57;
  localparam logic [6:0] MN_RNZ   = 7'd58;
  localparam logic [6:0] MN_RST   = 7'd66;
  localparam logic [6:0] MN_PCHL  = 7'd67;
  localparam logic [6:0] MN_PUSH  = 7'd68;
  localparam logic [6:0] MN_POP   = 7'd69;
  localparam logic [6:0] MN_XTHL  = 7'd70;
  localparam logic [6:0] MN_SPHL  = 7'd71;
  localparam logic [6:0] MN_IN    = 7'd72;
  localparam logic [6:0] MN_OUT   = 7'd73;
  localparam logic [6:0] MN_EI    = 7'd74;
  localparam logic [6:0] MN_DI    = 7'd75;
  localparam logic [6:0] MN_HLT   = 7'd76;
  localparam logic [6:0] MN_NOP   = 7'd77;
  localparam logic [6:0] MN_UNDEF = 7'd79;

  localparam logic [3:0] REG_NONE = 4'd8;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic [6:0] mnemonic;
    logic [3:0] first_reg;
    logic [3:0] second_reg;
    logic [2:0] rst_num;
    logic [1:0] length;
  } dec_t;

  typedef struct packed {
    logic [15:0] instr_address;
    logic [7:0]  opcode;
    logic [6:0]  mnemonic;
    logic [3:0]  first_reg;
    logic [3:0]  second_reg;
    logic [15:0] operand;
    logic [1:0]  length;
    logic        truncated;
  } rec_t;

endpackage

/* design/i8080_dec_if.sv */
// interfaces: code byte channel and decoded record channel
interface i8080_dec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_stream;

  modport source (output valid, output code_byte, output end_of_stream, input ready);
  modport sink (input valid, input code_byte, input end_of_stream, output ready);
endinterface

interface i8080_dec_rec_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_address;
  logic [7:0]  opcode;
  logic [6:0]  mnemonic;
  logic [3:0]  first_reg;
  logic [3:0]  second_reg;
  logic [15:0] operand;
  logic [1:0]  length;
  logic        truncated;

  modport source (
    output valid, output instr_address, output opcode, output mnemonic,
    output first_reg, output second_reg, output operand, output length,
    output truncated, input ready
  );
  modport sink (
    input valid, input instr_address, input opcode, input mnemonic,
    input first_reg, input second_reg, input operand, input length,
    input truncated, output ready
  );
endinterface

/* design/i8080_dec_table.sv */
// opcode table: mnemonic, register fields and length of one opcode byte
module i8080_dec_table (
  input  logic [7:0]          op,
  output i8080_dec_pkg::dec_t dec
);

  logic [1:0] q;
  logic [2:0] y;
  logic [2:0] z;
  logic [1:0] p;
  logic       odd;

  assign q   = op[7:6];
  assign y   = op[5:3];
  assign z   = op[2:0];
  assign p   = op[5:4];
  assign odd = op[3];

  always_comb begin
    dec.mnemonic   = i8080_dec_pkg::MN_UNDEF;
    dec.first_reg  = i8080_dec_pkg::REG_NONE;
    dec.second_reg = i8080_dec_pkg::REG_NONE;
    dec.rst_num    = 3'd0;
    dec.length     = i8080_dec_pkg::LEN_ONE;
    case (q)
      2'd1: begin
        if (y == 3'd6 && z == 3'd6) begin
          dec.mnemonic = i8080_dec_pkg::MN_HLT;
        end else begin
          dec.mnemonic   = i8080_dec_pkg::MN_MOV;
          dec.first_reg  = {1'b0, y};
          dec.second_reg = {1'b0, z};
        end
      end
      2'd2: begin
        dec.mnemonic   = i8080_dec_pkg::MN_ADD + 7'(y);
        dec.second_reg = {1'b0, z};
      end
      2'd0: begin
        case (z)
          3'd0: begin
            if (y == 3'd0) dec.mnemonic = i8080_dec_pkg::MN_NOP;
          end
          3'd1: begin
            dec.first_reg = {2'b00, p};
            if (odd) begin
              dec.mnemonic = i8080_dec_pkg::MN_DAD;
            end else begin
              dec.mnemonic = i8080_dec_pkg::MN_LXI;
              dec.length   = i8080_dec_pkg::LEN_THREE;
            end
          end
          3'd2: begin
            case (y)
              3'd4: begin
                dec.mnemonic = i8080_dec_pkg::MN_SHLD;
                dec.length   = i8080_dec_pkg::LEN_THREE;
              end
              3'd5: begin
                dec.mnemonic = i8080_dec_pkg::MN_LHLD;
                dec.length   = i8080_dec_pkg::LEN_THREE;
              end
              3'd6: begin
                dec.mnemonic = i8080_dec_pkg::MN_STA;
                dec.length   = i8080_dec_pkg::LEN_THREE;
              end
              3'd7: begin
                dec.mnemonic = i8080_dec_pkg::MN_LDA;
                dec.length   = i8080_dec_pkg::LEN_THREE;
              end
              default: begin
                dec.mnemonic  = odd ? i8080_dec_pkg::MN_LDAX : i8080_dec_pkg::MN_STAX;
                dec.first_reg = {2'b00, p};
              end
            endcase
          end
          3'd3: begin
            dec.mnemonic  = odd ? i8080_dec_pkg::MN_DCX : i8080_dec_pkg::MN_INX;
            dec.first_reg = {2'b00, p};
          end
          3'd4: begin
            dec.mnemonic  = i8080_dec_pkg::MN_INR;
            dec.first_reg = {1'b0, y};
          end
          3'd5: begin
            dec.mnemonic  = i8080_dec_pkg::MN_DCR;
            dec.first_reg = {1'b0, y};
          end
          3'd6: begin
            dec.mnemonic  = i8080_dec_pkg::MN_MVI;
            dec.first_reg = {1'b0, y};
            dec.length    = i8080_dec_pkg::LEN_TWO;
          end
          default: begin
            dec.mnemonic = i8080_dec_pkg::MN_RLC + 7'(y);
          end
        endcase
      end
      default: begin
        case (z)
          3'd0: dec.mnemonic = i8080_dec_pkg::MN_RNZ + 7'(y);
          3'd1: begin
            if (!odd) begin
              dec.mnemonic  = i8080_dec_pkg::MN_POP;
              dec.first_reg = {2'b00, p};
            end else begin
              case (p)
                2'd0: dec.mnemonic = i8080_dec_pkg::MN_RET;
                2'd2: dec.mnemonic = i8080_dec_pkg::MN_PCHL;
                2'd3: dec.mnemonic = i8080_dec_pkg::MN_SPHL;
                default: dec.mnemonic = i8080_dec_pkg::MN_UNDEF;
              endcase
            end
          end
          3'd2: begin
            dec.mnemonic = i8080_dec_pkg::MN_JNZ + 7'(y);
            dec.length   = i8080_dec_pkg::LEN_THREE;
          end
          3'd3: begin
            case (y)
              3'd0: begin
                dec.mnemonic = i8080_dec_pkg::MN_JMP;
                dec.length   = i8080_dec_pkg::LEN_THREE;
              end
              3'd2: begin
                dec.mnemonic = i8080_dec_pkg::MN_OUT;
                dec.length   = i8080_dec_pkg::LEN_TWO;
              end
              3'd3: begin
                dec.mnemonic = i8080_dec_pkg::MN_IN;
                dec.length   = i8080_dec_pkg::LEN_TWO;
              end
              3'd4: dec.mnemonic = i8080_dec_pkg::MN_XTHL;
              3'd5: dec.mnemonic = i8080_dec_pkg::MN_XCHG;
              3'd6: dec.mnemonic = i8080_dec_pkg::MN_DI;
              3'd7: dec.mnemonic = i8080_dec_pkg::MN_EI;
              default: dec.mnemonic = i8080_dec_pkg::MN_UNDEF;
            endcase
          end
          3'd4: begin
            dec.mnemonic = i8080_dec_pkg::MN_CNZ + 7'(y);
            dec.length   = i8080_dec_pkg::LEN_THREE;
          end
          3'd5: begin
            if (!odd) begin
              dec.mnemonic  = i8080_dec_pkg::MN_PUSH;
              dec.first_reg = {2'b00, p};
            end else if (p == 2'd0) begin
              dec.mnemonic = i8080_dec_pkg::MN_CALL;
              dec.length   = i8080_dec_pkg::LEN_THREE;
            end
          end
          3'd6: begin
            dec.mnemonic = i8080_dec_pkg::MN_ADI + 7'(y);
            dec.length   = i8080_dec_pkg::LEN_TWO;
          end
          default: begin
            dec.mnemonic = i8080_dec_pkg::MN_RST;
            dec.rst_num  = y;
          end
        endcase
      end
    endcase
  end

endmodule

/* design/i8080_dec_track.sv */
// stream tracker: byte addresses, operand collection and record assembly
module i8080_dec_track (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                take,
  input  logic [7:0]          code_byte,
  input  logic                end_of_stream,
  output logic                emit,
  output i8080_dec_pkg::rec_t rec
);

  logic [15:0]         start_address;
  logic [15:0]         byte_address;
  logic                fresh;
  logic [1:0]          bytes_remaining;
  logic [1:0]          bytes_remaining_next;
  logic [7:0]          pending_opcode;
  i8080_dec_pkg::dec_t pending_dec;
  logic [15:0]         start_of_instr;
  logic [7:0]          low_operand;
  logic [15:0]         addr;
  i8080_dec_pkg::dec_t dec;

  i8080_dec_table u_table (
    .op  (code_byte),
    .dec (dec)
  );

  assign addr = fresh ? start_address : byte_address;

  always_comb begin
    emit                 = 1'b0;
    bytes_remaining_next = bytes_remaining;
    rec.instr_address    = start_of_instr;
    rec.opcode           = pending_opcode;
    rec.mnemonic         = pending_dec.mnemonic;
    rec.first_reg        = pending_dec.first_reg;
    rec.second_reg       = pending_dec.second_reg;
    rec.length           = pending_dec.length;
    rec.operand          = {8'd0, code_byte};
    rec.truncated        = 1'b0;
    case (bytes_remaining)
      2'd0: begin
        rec.instr_address = addr;
        rec.opcode        = code_byte;
        rec.mnemonic      = dec.mnemonic;
        rec.first_reg     = dec.first_reg;
        rec.second_reg    = dec.second_reg;
        rec.length        = dec.length;
        if (dec.length == i8080_dec_pkg::LEN_ONE) begin
          emit        = 1'b1;
          rec.operand = {13'd0, dec.rst_num};
        end else begin
          bytes_remaining_next = dec.length - 2'd1;
          emit                 = end_of_stream;
          rec.operand          = 16'd0;
          rec.truncated        = 1'b1;
        end
      end
      2'd2: begin
        bytes_remaining_next = 2'd1;
        emit                 = end_of_stream;
        rec.truncated        = 1'b1;
      end
      default: begin
        bytes_remaining_next = 2'd0;
        emit                 = 1'b1;
        if (pending_dec.length == i8080_dec_pkg::LEN_THREE) begin
          rec.operand = {code_byte, low_operand};
        end
      end
    endcase
    if (end_of_stream) bytes_remaining_next = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address   <= 16'd0;
      byte_address    <= 16'd0;
      fresh           <= 1'b1;
      bytes_remaining <= 2'd0;
    end else begin
      if (cfg_wr_en) start_address <= cfg_wr_data;
      if (take) begin
        byte_address    <= addr + 16'd1;
        fresh           <= end_of_stream;
        bytes_remaining <= bytes_remaining_next;
      end
    end
  end

  // operand collection, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      if (bytes_remaining == 2'd0) begin
        pending_opcode <= code_byte;
        pending_dec    <= dec;
        start_of_instr <= addr;
      end
      if (bytes_remaining == 2'd2) low_operand <= code_byte;
    end
  end

endmodule

/* design/i8080_instruction_decoder.sv */
// top level of the 8080 instruction decoder: tracker plus result register
//
//   channel   dir   beat                                   handshake
//   code      in    code_byte, end_of_stream               valid/ready
//   record    out   decoded instruction record             valid/ready
//   cfg       in    start_address                          cfg_wr_en, no ready
//
// one code beat per cycle, back to back while code.ready is high; a record shows in the cycle after its last byte
// code.ready is low only while a record sits in the result register and record.ready is low
// every beat with end_of_stream produces a record; the next beat starts at start_address
// rst is synchronous and clears the tracker and the result register valid
module i8080_instruction_decoder (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [15:0]             cfg_wr_data,
  i8080_dec_byte_if.sink          code,
  i8080_dec_rec_if.source         record
);

  logic                take;
  logic                emit;
  i8080_dec_pkg::rec_t rec;
  i8080_dec_pkg::rec_t rec_q;
  logic                rec_valid;

  assign code.ready = !rec_valid || record.ready;
  assign take       = code.valid && code.ready;

  i8080_dec_track u_track (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .take          (take),
    .code_byte     (code.code_byte),
    .end_of_stream (code.end_of_stream),
    .emit          (emit),
    .rec           (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (take && emit) begin
      rec_valid <= 1'b1;
    end else if (record.ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) rec_q <= rec;
  end

  assign record.valid         = rec_valid;
  assign record.instr_address = rec_q.instr_address;
  assign record.opcode        = rec_q.opcode;
  assign record.mnemonic      = rec_q.mnemonic;
  assign record.first_reg     = rec_q.first_reg;
  assign record.second_reg    = rec_q.second_reg;
  assign record.operand       = rec_q.operand;
  assign record.length        = rec_q.length;
  assign record.truncated     = rec_q.truncated;

endmodule

/* design/i8080_dec_checker.sv */
// port checker for the 8080 instruction decoder, bound to the top level
`include "i8080_instruction_decoder_assert.svh"

module i8080_dec_checker (
  input logic        clk,
  input logic        rst,
  input logic        code_valid,
  input logic        code_ready,
  input logic        code_eos,
  input logic        rec_valid,
  input logic        rec_ready,
  input logic [6:0]  rec_mnemonic,
  input logic [3:0]  rec_first_reg,
  input logic [15:0] rec_operand,
  input logic [1:0]  rec_length,
  input logic        rec_truncated
);

  // a stalled record beat holds
  `I8080_DEC_ASSERT_NEXT(a_rec_hold, clk, rst, rec_valid && !rec_ready, rec_valid && $stable(rec_operand) && $stable(rec_mnemonic))

  // the last byte of a stream always yields a record
  `I8080_DEC_ASSERT_NEXT(a_eos_emits, clk, rst, code_valid && code_ready && code_eos, rec_valid)

  // an empty result register never stalls the input
  `I8080_DEC_ASSERT_NOW(a_ready_when_empty, clk, rst, !rec_valid, code_ready)

  // only multi-byte instructions can be cut short
  `I8080_DEC_ASSERT_NOW(a_trunc_len, clk, rst, rec_valid && rec_truncated, rec_length != i8080_dec_pkg::LEN_ONE)

  // undefined opcodes are single bytes with no fields
  `I8080_DEC_ASSERT_NOW(a_undef_plain, clk, rst, rec_valid && rec_mnemonic == i8080_dec_pkg::MN_UNDEF, rec_length == i8080_dec_pkg::LEN_ONE && rec_first_reg == i8080_dec_pkg::REG_NONE && rec_operand == 16'd0)

endmodule

bind i8080_instruction_decoder i8080_dec_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .code_valid    (code.valid),
  .code_ready    (code.ready),
  .code_eos      (code.end_of_stream),
  .rec_valid     (record.valid),
  .rec_ready     (record.ready),
  .rec_mnemonic  (record.mnemonic),
  .rec_first_reg (record.first_reg),
  .rec_operand   (record.operand),
  .rec_length    (record.length),
  .rec_truncated (record.truncated)
);

/* verif/tb_top.sv */
// testbench for the 8080 instruction decoder: byte stream driver, record checker, scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i8080_dec_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class decoder_scoreboard;
    rec_t        due_records[$];
    logic [15:0] start_addr;
    logic [15:0] next_addr;
    logic [15:0] instr_addr;
    logic [7:0]  held_op;
    logic [7:0]  low_byte;
    logic [1:0]  bytes_left;
    bit          fresh;
    int          errors;
    int          records;
    int          truncs;
    int          undefs;

    function new();
      start_addr = '0;
      next_addr  = '0;
      instr_addr = '0;
      held_op    = '0;
      low_byte   = '0;
      bytes_left = '0;
      fresh      = 1'b1;
      errors     = 0;
      records    = 0;
      truncs     = 0;
      undefs     = 0;
    endfunction

    function void set_start(logic [15:0] v);
      start_addr = v;
    endfunction

    function dec_t decode_opcode(logic [7:0] op);
      logic [2:0] y;
      logic [2:0] z;
      logic [1:0] p;
      logic       odd;
      dec_t       d;
      y   = op[5:3];
      z   = op[2:0];
      p   = y[2:1];
      odd = y[0];
      d.mnemonic   = MN_UNDEF;
      d.first_reg  = REG_NONE;
      d.second_reg = REG_NONE;
      d.rst_num    = '0;
      d.length     = LEN_ONE;
      case (op[7:6])
        2'd1: begin
          if (op == 8'h76) begin
            d.mnemonic = MN_HLT;
          end else begin
            d.mnemonic   = MN_MOV;
            d.first_reg  = {1'b0, y};
            d.second_reg = {1'b0, z};
          end
        end
        2'd2: begin
          d.mnemonic   = MN_ADD + 7'(y);
          d.second_reg = {1'b0, z};
        end
        2'd0: begin
          case (z)
            3'd0: if (op == 8'h00) d.mnemonic = MN_NOP;
            3'd1: begin
              d.first_reg = {2'b00, p};
              if (odd) begin
                d.mnemonic = MN_DAD;
              end else begin
                d.mnemonic = MN_LXI;
                d.length   = LEN_THREE;
              end
            end
            3'd2: begin
              if (!y[2]) begin
                d.mnemonic  = odd ? MN_LDAX : MN_STAX;
                d.first_reg = {2'b00, p};
              end else begin
                d.length = LEN_THREE;
                case (y)
                  3'd4:    d.mnemonic = MN_SHLD;
                  3'd5:    d.mnemonic = MN_LHLD;
                  3'd6:    d.mnemonic = MN_STA;
                  default: d.mnemonic = MN_LDA;
                endcase
              end
            end
            3'd3: begin
              d.mnemonic  = odd ? MN_DCX : MN_INX;
              d.first_reg = {2'b00, p};
            end
            3'd4: begin
              d.mnemonic  = MN_INR;
              d.first_reg = {1'b0, y};
            end
            3'd5: begin
              d.mnemonic  = MN_DCR;
              d.first_reg = {1'b0, y};
            end
            3'd6: begin
              d.mnemonic  = MN_MVI;
              d.first_reg = {1'b0, y};
              d.length    = LEN_TWO;
            end
            default: d.mnemonic = MN_RLC + 7'(y);
          endcase
        end
        default: begin
          case (z)
            3'd0: d.mnemonic = MN_RNZ + 7'(y);
            3'd1: begin
              if (!odd) begin
                d.mnemonic  = MN_POP;
                d.first_reg = {2'b00, p};
              end else if (p == 2'd0) begin
                d.mnemonic = MN_RET;
              end else if (p == 2'd2) begin
                d.mnemonic = MN_PCHL;
              end else if (p == 2'd3) begin
                d.mnemonic = MN_SPHL;
              end
            end
            3'd2: begin
              d.mnemonic = MN_JNZ + 7'(y);
              d.length   = LEN_THREE;
            end
            3'd3: begin
              case (y)
                3'd0: begin
                  d.mnemonic = MN_JMP;
                  d.length   = LEN_THREE;
                end
                3'd2: begin
                  d.mnemonic = MN_OUT;
                  d.length   = LEN_TWO;
                end
                3'd3: begin
                  d.mnemonic = MN_IN;
                  d.length   = LEN_TWO;
                end
                3'd4: d.mnemonic = MN_XTHL;
                3'd5: d.mnemonic = MN_XCHG;
                3'd6: d.mnemonic = MN_DI;
                3'd7: d.mnemonic = MN_EI;
                default: ;
              endcase
            end
            3'd4: begin
              d.mnemonic = MN_CNZ + 7'(y);
              d.length   = LEN_THREE;
            end
            3'd5: begin
              if (!odd) begin
                d.mnemonic  = MN_PUSH;
                d.first_reg = {2'b00, p};
              end else if (p == 2'd0) begin
                d.mnemonic = MN_CALL;
                d.length   = LEN_THREE;
              end
            end
            3'd6: begin
              d.mnemonic = MN_ADI + 7'(y);
              d.length   = LEN_TWO;
            end
            default: begin
              d.mnemonic = MN_RST;
              d.rst_num  = y;
            end
          endcase
        end
      endcase
      return d;
    endfunction

    function void push_record(logic [15:0] addr, logic [7:0] op, dec_t d,
                              logic [15:0] operand, logic trunc);
      rec_t r;
      r.instr_address = addr;
      r.opcode        = op;
      r.mnemonic      = d.mnemonic;
      r.first_reg     = d.first_reg;
      r.second_reg    = d.second_reg;
      r.operand       = operand;
      r.length        = d.length;
      r.truncated     = trunc;
      due_records.push_back(r);
    endfunction

    function void note_beat(logic [7:0] b, logic eos);
      logic [15:0] addr;
      logic [15:0] value;
      dec_t        d;
      addr      = fresh ? start_addr : next_addr;
      fresh     = 1'b0;
      next_addr = addr + 16'd1;
      if (bytes_left == 2'd0) begin
        d = decode_opcode(b);
        if (d.length == LEN_ONE) begin
          push_record(addr, b, d, {13'd0, d.rst_num}, 1'b0);
        end else begin
          held_op    = b;
          instr_addr = addr;
          bytes_left = d.length - 2'd1;
          low_byte   = '0;
          if (eos) push_record(addr, b, d, 16'd0, 1'b1);
        end
      end else begin
        d = decode_opcode(held_op);
        if (bytes_left == 2'd2) begin
          low_byte   = b;
          bytes_left = 2'd1;
          if (eos) push_record(instr_addr, held_op, d, {8'd0, b}, 1'b1);
        end else begin
          value = (d.length == LEN_THREE) ? {b, low_byte} : {8'd0, b};
          push_record(instr_addr, held_op, d, value, 1'b0);
          bytes_left = 2'd0;
        end
      end
      if (eos) begin
        bytes_left = 2'd0;
        fresh      = 1'b1;
      end
    endfunction

    function void diff_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (exp_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (due_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected record, expected none, got %h", $time, got);
        return;
      end
      want = due_records.pop_front();
      records++;
      if (want.truncated) truncs++;
      if (want.mnemonic == MN_UNDEF) undefs++;
      diff_field("instr_address", want.instr_address, got.instr_address);
      diff_field("opcode", 16'(want.opcode), 16'(got.opcode));
      diff_field("mnemonic", 16'(want.mnemonic), 16'(got.mnemonic));
      diff_field("first_reg", 16'(want.first_reg), 16'(got.first_reg));
      diff_field("second_reg", 16'(want.second_reg), 16'(got.second_reg));
      diff_field("operand", want.operand, got.operand);
      diff_field("length", 16'(want.length), 16'(got.length));
      diff_field("truncated", 16'(want.truncated), 16'(got.truncated));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  i8080_dec_byte_if code_if ();
  i8080_dec_rec_if  rec_if ();

  i8080_instruction_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .code        (code_if),
    .record      (rec_if)
  );

  decoder_scoreboard sb = new();

  int send_idle  = 0;
  int recv_idle  = 0;
  int stall_len  = 0;
  int beats_sent = 0;
  int cycles     = 0;

  initial begin
    code_if.valid         = 1'b0;
    code_if.code_byte     = '0;
    code_if.end_of_stream = 1'b0;
    rec_if.ready          = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (stall_len > 0) begin
        rec_if.ready <= 1'b0;
        stall_len--;
      end else begin
        rec_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    rec_t got;
    if (!rst && rec_if.valid === 1'b1 && rec_if.ready === 1'b1) begin
      got.instr_address = rec_if.instr_address;
      got.opcode        = rec_if.opcode;
      got.mnemonic      = rec_if.mnemonic;
      got.first_reg     = rec_if.first_reg;
      got.second_reg    = rec_if.second_reg;
      got.operand       = rec_if.operand;
      got.length        = rec_if.length;
      got.truncated     = rec_if.truncated;
      sb.check_record(got);
    end
  end

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_beat(input logic [7:0] b, input logic e);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      code_if.valid <= 1'b0;
      @(negedge clk);
    end
    code_if.valid         <= 1'b1;
    code_if.code_byte     <= b;
    code_if.end_of_stream <= e;
    do @(posedge clk); while (code_if.ready !== 1'b1);
    sb.note_beat(b, e);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    code_if.valid <= 1'b0;
    while (sb.due_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    sb.set_start(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one opcode with its operand bytes, sometimes cut short by end of stream
  task automatic send_instr();
    logic [7:0] op;
    logic [7:0] b;
    logic       e;
    dec_t       od;
    int         len;
    int         cut;
    op  = 8'($urandom_range(255));
    od  = sb.decode_opcode(op);
    len = int'(od.length);
    cut = ($urandom_range(19) == 0) ? int'($urandom_range(len, 1)) : 0;
    for (int i = 1; i <= len; i++) begin
      b = (i == 1) ? op : 8'($urandom_range(255));
      e = (i == cut) || (i == len && $urandom_range(15) == 0);
      send_beat(b, e);
      if (e) break;
    end
  endtask

  task automatic send_random(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) begin
      if ($urandom_range(99) < 80) begin
        send_instr();
      end else begin
        send_beat(8'($urandom_range(255)), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic run_directed();
    logic [8:0] seq [23];
    // {end_of_stream, byte}
    seq = '{9'h000, 9'h001, 9'h034, 9'h012, 9'h076, 9'h040, 9'h07F, 9'h03E,
            9'h0FF, 9'h0CF, 9'h0FF, 9'h0C7, 9'h0CB, 9'h008, 9'h0FD, 9'h0C3,
            9'h0FF, 9'h1FF, 9'h1C3, 9'h0CD, 9'h155, 9'h1D3, 9'h180};
    foreach (seq[i]) send_beat(seq[i][7:0], seq[i][8]);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: address wrap, every length, undefined opcodes, truncation
    write_start(16'hFFFE);
    run_directed();
    wait_drained();

    send_idle = 10;
    recv_idle = 76;
    write_start(16'($urandom_range(65535)));
    send_random(120);
    wait_drained();
    send_random(110);
    wait_drained();

    send_idle = 76;
    recv_idle = 10;
    write_start(16'hFFFF);
    send_random(230);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    write_start(16'h0000);
    send_random(30);
    stall_len = 400;
    send_random(200);
    wait_drained();
    repeat (10) @(posedge clk);

    $display("covered %0d code beats and %0d records, %0d of them truncated, %0d undefined",
             beats_sent, sb.records, sb.truncs, sb.undefs);
    $display("start addresses 0000, fffe, ffff and one random value, three idle mixes");
    if (sb.errors == 0 && sb.due_records.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+design
design/i8080_dec_pkg.sv
design/i8080_dec_if.sv
design/i8080_dec_table.sv
design/i8080_dec_track.sv
design/i8080_instruction_decoder.sv
design/i8080_dec_checker.sv
verif/tb_top.sv
